// ===== rtl/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg: shared types and codes for the sample voice mixer
// Item layouts, action codes, voice table sizes and the per-voice read
// request passed between the sequencer and the scaling unit.
// ----------------------------------------------------------------------------
`default_nettype none
package svm_pkg;

    localparam int ONESHOT_VOICES = 128;
    localparam int LOOP_VOICES    = 8;
    localparam int SAMPLE_DEPTH   = 65536;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_WRITE     = 3'd1,
        ACT_START_ONE = 3'd2,
        ACT_START_LP  = 3'd3,
        ACT_SET_STEP  = 3'd4,
        ACT_SET_VOL   = 3'd5,
        ACT_NONE6     = 3'd6,
        ACT_NONE7     = 3'd7
    } action_t;

    localparam logic RK_FRAME = 1'b0;
    localparam logic RK_SLOT  = 1'b1;

    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        address;
        logic signed [15:0] sample_value;
        logic [16:0]        length;
        logic [15:0]        volume;
        logic [2:0]         loop_index;
        logic [15:0]        step;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] mixed_sample;
        logic [6:0]         slot;
        logic               slot_ok;
    } out_item_t;

    // one entry of the one-shot voice table
    typedef struct packed {
        logic [15:0] base;
        logic [16:0] len;
        logic [16:0] pos;
        logic [15:0] gain;
    } os_voice_t;

    // request to the shared scale unit: a raw sample plus its gain
    typedef struct packed {
        logic        valid;
        logic [15:0] raw;
        logic [15:0] gain;
    } scale_req_t;

endpackage
`default_nettype wire

// ===== rtl/sample_voice_mixer_top.sv =====
// ----------------------------------------------------------------------------
// sample_voice_mixer_top: wavetable sample mixer
// Input channel (in_valid/in_ready/in_data) carries one action item; output
// channel (out_valid/out_ready/out_data) carries one result for a tick or a
// start, none for other actions. One item is worked at a time; in_ready is
// low while an item is in progress or a result waits.
// A sample write or a step/volume change is applied in S_DO. A start reads
// the slots one after another, with a table read and a check per slot, then
// gives the result.
// A tick visits every one-shot slot (table read, sample RAM read, scale and
// position update; an idle slot skips the scale and update) and then every
// loop slot (sample RAM read, scale, 9-step phase modulo; an idle slot skips
// all but the read); the single-port voice table and sample RAM, the shared
// multiplier and the compare-and-subtract modulo set the length of a tick.
// Reset clears the loop slots at once and the one-shot table by a pass over
// every entry, during which in_ready is low; the sample RAM is not
// cleared and must be written before a voice plays it.
// A stalled receiver holds the result in the output register and the block
// takes no new item until it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module sample_voice_mixer_top
    import svm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);
    localparam int OW = (ONESHOT_VOICES > 1) ? $clog2(ONESHOT_VOICES) : 1;
    localparam int LW = (LOOP_VOICES > 1) ? $clog2(LOOP_VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DO, S_OS_VRD, S_OS_RD, S_OS_WAIT, S_OS_NEXT,
        S_LP_RD, S_LP_WAIT, S_LP_MOD, S_LP_NEXT, S_DRAIN1, S_DRAIN2,
        S_FIND_RD, S_FIND, S_OUT
    } state_t;

    state_t      state_reg;
    in_item_t    item_reg;
    logic [8:0]  idx_reg;
    out_item_t   out_reg;
    logic [24:0] rem_reg;
    logic [32:0] div_reg;
    logic [3:0]  cnt_reg;

    // loop voice state in registers with fixed index per slot
    logic [15:0] lp_base_reg [LOOP_VOICES];
    logic [16:0] lp_len_reg  [LOOP_VOICES];
    logic [24:0] lp_ph_reg   [LOOP_VOICES];
    logic [15:0] lp_gain_reg [LOOP_VOICES];
    logic [15:0] lp_rate_reg [LOOP_VOICES];

    logic [OW-1:0] oi;
    logic [LW-1:0] li;
    assign oi = idx_reg[OW-1:0];
    assign li = idx_reg[LW-1:0];

    logic          os_act, lp_act;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [15:0]   ram_rdata;
    logic          vo_we;
    os_voice_t     vo_wdata;
    os_voice_t     os_q;
    logic [24:0]   ph_sum;
    logic [24:0]   span;
    logic [24:0]   rem_next;
    scale_req_t    sreq;
    logic          sclear;
    logic [15:0]   acc;

    assign os_act = os_q.pos < os_q.len;
    assign lp_act = lp_len_reg[li] != 17'd0;
    assign span   = {lp_len_reg[li], 8'd0};
    // phase < span and rate < 2^16, so the quotient stays below 2^9
    assign ph_sum   = lp_ph_reg[li] + {9'd0, lp_rate_reg[li]};
    assign rem_next = ({8'd0, rem_reg} >= div_reg) ? rem_reg - div_reg[24:0] : rem_reg;

    always_comb
    begin
        ram_we   = (state_reg == S_DO) && (item_reg.action == ACT_WRITE);
        ram_addr = item_reg.address[AW-1:0];
        if (state_reg == S_OS_RD)
        begin
            ram_addr = AW'({1'b0, os_q.base} + os_q.pos);
        end
        else if (state_reg == S_LP_RD)
        begin
            ram_addr = AW'({1'b0, lp_base_reg[li]} + lp_ph_reg[li][24:8]);
        end
    end

    svm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item_reg.sample_value),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        vo_we    = 1'b0;
        vo_wdata = '0;
        case (state_reg)
            S_CLR:
            begin
                vo_we = 1'b1;
            end
            S_OS_WAIT:
            begin
                vo_we        = 1'b1;
                vo_wdata     = os_q;
                vo_wdata.pos = os_q.pos + 17'd1;
            end
            S_FIND:
            begin
                if (item_reg.action == ACT_START_ONE && !os_act)
                begin
                    vo_we    = 1'b1;
                    vo_wdata = '{item_reg.address, item_reg.length, 17'd0, item_reg.volume};
                end
            end
            default: ;
        endcase
    end

    svm_ram #(.WIDTH($bits(os_voice_t)), .DEPTH(ONESHOT_VOICES)) u_voice_ram (
        .clk   (clk),
        .we    (vo_we),
        .addr  (oi),
        .wdata (vo_wdata),
        .rdata (os_q)
    );

    always_comb
    begin
        sreq.valid = 1'b0;
        sreq.raw   = ram_rdata;
        sreq.gain  = os_q.gain;
        if (state_reg == S_OS_WAIT)
        begin
            sreq.valid = 1'b1;
        end
        else if (state_reg == S_LP_WAIT)
        begin
            sreq.valid = 1'b1;
            sreq.gain  = lp_gain_reg[li];
        end
    end
    assign sclear = (state_reg == S_IDLE);

    svm_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (sclear),
        .req   (sreq),
        .acc   (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= '0;
            out_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            cnt_reg   <= '0;
            for (int k = 0; k < LOOP_VOICES; k++)
            begin
                lp_base_reg[k] <= '0;
                lp_len_reg[k]  <= '0;
                lp_ph_reg[k]   <= '0;
                lp_rate_reg[k] <= '0;
                lp_gain_reg[k] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_CLR:
                begin
                    if (32'(idx_reg) == ONESHOT_VOICES - 1)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                end
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= S_DO;
                    end
                end
                S_DO:
                begin
                    case (item_reg.action)
                        ACT_TICK:      state_reg <= S_OS_VRD;
                        ACT_START_ONE,
                        ACT_START_LP:  state_reg <= S_FIND_RD;
                        ACT_SET_STEP:
                        begin
                            if (32'(item_reg.loop_index) < LOOP_VOICES)
                            begin
                                lp_rate_reg[item_reg.loop_index[LW-1:0]] <= item_reg.step;
                            end
                            state_reg <= S_IDLE;
                        end
                        ACT_SET_VOL:
                        begin
                            if (32'(item_reg.loop_index) < LOOP_VOICES)
                            begin
                                lp_gain_reg[item_reg.loop_index[LW-1:0]] <= item_reg.volume;
                            end
                            state_reg <= S_IDLE;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_OS_VRD: state_reg <= S_OS_RD;
                S_OS_RD:
                begin
                    state_reg <= os_act ? S_OS_WAIT : S_OS_NEXT;
                end
                S_OS_WAIT:
                begin
                    state_reg <= S_OS_NEXT;
                end
                S_OS_NEXT:
                begin
                    if (32'(idx_reg) == ONESHOT_VOICES - 1)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_LP_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 9'd1;
                        state_reg <= S_OS_VRD;
                    end
                end
                S_LP_RD:
                begin
                    state_reg <= lp_act ? S_LP_WAIT : S_LP_NEXT;
                end
                S_LP_WAIT:
                begin
                    rem_reg   <= ph_sum;
                    div_reg   <= {span, 8'd0};
                    cnt_reg   <= 4'd8;
                    state_reg <= S_LP_MOD;
                end
                S_LP_MOD:
                begin
                    // reduce the phase by the span, one quotient bit per cycle
                    rem_reg <= rem_next;
                    div_reg <= div_reg >> 1;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                    begin
                        lp_ph_reg[li] <= rem_next;
                        state_reg     <= S_LP_NEXT;
                    end
                end
                S_LP_NEXT:
                begin
                    if (32'(idx_reg) == LOOP_VOICES - 1)
                    begin
                        state_reg <= S_DRAIN1;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 9'd1;
                        state_reg <= S_LP_RD;
                    end
                end
                S_DRAIN1: state_reg <= S_DRAIN2;
                S_DRAIN2:
                begin
                    out_reg   <= '{RK_FRAME, acc, 7'd0, 1'b0};
                    state_reg <= S_OUT;
                end
                S_FIND_RD: state_reg <= S_FIND;
                S_FIND:
                begin
                    // check one slot per visit; stop at the first free one
                    if (item_reg.action == ACT_START_ONE ? !os_act : !lp_act)
                    begin
                        out_reg <= '{RK_SLOT, 16'd0, idx_reg[6:0], 1'b1};
                        if (item_reg.action != ACT_START_ONE)
                        begin
                            lp_base_reg[li] <= item_reg.address;
                            lp_len_reg[li]  <= item_reg.length;
                            lp_ph_reg[li]   <= '0;
                            lp_gain_reg[li] <= item_reg.volume;
                            lp_rate_reg[li] <= '0;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (32'(idx_reg) == ((item_reg.action == ACT_START_ONE) ?
                             ONESHOT_VOICES - 1 : LOOP_VOICES - 1))
                    begin
                        out_reg   <= '{RK_SLOT, 16'd0, 7'd0, 1'b0};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 9'd1;
                        state_reg <= S_FIND_RD;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    // a result is offered only after an item was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result raised while idle");
    // the block never takes an item while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken with result pending");
    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");
    // slot_ok is raised only on slot answers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.slot_ok |-> out_data.result_kind == RK_SLOT)
        else $error("slot_ok on frame result");
endmodule
`default_nettype wire

// ===== rtl/svm_ram.sv =====
// ----------------------------------------------------------------------------
// svm_ram: generic single-port RAM
// A write when we is high and a read every cycle; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/svm_scale.sv =====
// ----------------------------------------------------------------------------
// svm_scale: shared voice scaling unit
// Multiply a signed sample by a Q8.8 gain, truncate toward zero, saturate,
// and wrap-add into the frame accumulator. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_scale
    import svm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire scale_req_t  req,
    output logic [15:0]      acc
);
    logic               p_valid_reg;
    logic signed [32:0] prod_reg;
    logic [15:0]        acc_reg;
    logic signed [32:0] prod_next;
    logic signed [32:0] adj;
    logic signed [24:0] quo;
    logic [15:0]        sat;

    assign prod_next = $signed({{17{req.raw[15]}}, req.raw}) * $signed({17'd0, req.gain});

    always_comb
    begin
        // bias negatives so the shift truncates toward zero
        adj = prod_reg + (prod_reg[32] ? 33'sd255 : 33'sd0);
        quo = adj[32:8];
        if (quo > 25'sd32767)
        begin
            sat = 16'h7fff;
        end
        else if (quo < -25'sd32768)
        begin
            sat = 16'h8000;
        end
        else
        begin
            sat = quo[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            p_valid_reg <= req.valid;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (p_valid_reg)
            begin
                acc_reg <= acc_reg + sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

// ===== bench/sample_voice_mixer_top_tb.sv =====
// ----------------------------------------------------------------------------
// sample_voice_mixer_top_tb: self-checking bench for the sample voice mixer
// Drives action items through the input handshake, predicts every frame and
// slot answer from a behavioral mixer model, and compares results in order.
// ----------------------------------------------------------------------------
module sample_voice_mixer_top_tb
    import svm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ONE  = ONESHOT_VOICES;
    localparam int NUM_LOOP = LOOP_VOICES;
    localparam int LIMIT    = 2000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    sample_voice_mixer_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mixer state mirror
    logic [15:0] ram [int];
    logic [15:0] os_base [NUM_ONE];
    logic [16:0] os_len [NUM_ONE];
    logic [16:0] os_pos [NUM_ONE];
    logic [15:0] os_gain [NUM_ONE];
    logic [15:0] lp_base [NUM_LOOP];
    logic [16:0] lp_len [NUM_LOOP];
    logic [24:0] lp_phase [NUM_LOOP];
    logic [15:0] lp_gain [NUM_LOOP];
    logic [15:0] lp_rate [NUM_LOOP];

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        stim_done = 1'b0;

    function automatic logic [15:0] scaled_voice(logic [15:0] base, logic [16:0] offset,
                                                 logic [15:0] gain);
        logic [15:0] a;
        longint s;
        longint p;
        a = base + offset[15:0];
        s = ram.exists(a) ? longint'($signed(ram[a])) : 0;
        p = (s * longint'(gain)) / 256;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    function automatic void mix_predict(in_item_t it);
        out_item_t r;
        logic [15:0] acc;
        logic [31:0] span;
        bit found;
        int sl;
        r = '0;
        found = 1'b0;
        sl = 0;
        case (action_t'(it.action))
            ACT_TICK:
            begin
                acc = '0;
                for (int i = 0; i < NUM_ONE; i++)
                    if (os_pos[i] < os_len[i])
                    begin
                        acc += scaled_voice(os_base[i], os_pos[i], os_gain[i]);
                        os_pos[i] = os_pos[i] + 17'd1;
                    end
                for (int i = 0; i < NUM_LOOP; i++)
                    if (lp_len[i] != 0)
                    begin
                        span = {7'd0, lp_len[i], 8'd0};
                        acc += scaled_voice(lp_base[i], lp_phase[i][24:8], lp_gain[i]);
                        lp_phase[i] = 25'((32'(lp_phase[i]) + 32'(lp_rate[i])) % span);
                    end
                r.result_kind = RK_FRAME;
                r.mixed_sample = acc;
                expected_results.push_back(r);
            end
            ACT_WRITE: ram[it.address] = it.sample_value;
            ACT_START_ONE, ACT_START_LP:
            begin
                if (it.action == ACT_START_ONE)
                begin
                    for (int i = 0; i < NUM_ONE && !found; i++)
                        if (os_pos[i] >= os_len[i])
                        begin
                            found = 1'b1;
                            sl = i;
                        end
                    if (found)
                    begin
                        os_base[sl] = it.address;
                        os_len[sl] = it.length;
                        os_pos[sl] = '0;
                        os_gain[sl] = it.volume;
                    end
                end
                else
                begin
                    for (int i = 0; i < NUM_LOOP && !found; i++)
                        if (lp_len[i] == 0)
                        begin
                            found = 1'b1;
                            sl = i;
                        end
                    if (found)
                    begin
                        lp_base[sl] = it.address;
                        lp_len[sl] = it.length;
                        lp_phase[sl] = '0;
                        lp_gain[sl] = it.volume;
                        lp_rate[sl] = '0;
                    end
                end
                r.result_kind = RK_SLOT;
                r.slot = found ? 7'(sl) : 7'd0;
                r.slot_ok = found;
                expected_results.push_back(r);
            end
            ACT_SET_STEP: if (it.loop_index < NUM_LOOP) lp_rate[it.loop_index] = it.step;
            ACT_SET_VOL: if (it.loop_index < NUM_LOOP) lp_gain[it.loop_index] = it.volume;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // only bases whose whole span was written are started, so no voice reads
    // an unwritten entry
    logic [16:0] written_top = 0;

    function automatic in_item_t make_item(action_t a);
        in_item_t it;
        it = '0;
        it.action = a;
        it.address = 16'($urandom);
        it.sample_value = 16'($urandom);
        it.volume = 16'($urandom);
        it.loop_index = 3'($urandom);
        it.step = 16'($urandom);
        it.length = 17'($urandom);
        return it;
    endfunction

    function automatic void queue_start(action_t a, int len, logic [15:0] vol);
        in_item_t it;
        it = make_item(a);
        it.length = 17'(len);
        it.volume = vol;
        it.address = (len == 0) ? 16'($urandom) : 16'($urandom_range(0, written_top - len));
        pending_items.push_back(it);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data <= pending_items[0];
                    mix_predict(pending_items.pop_front());
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t w;
        cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                w = expected_results.pop_front();
                if (out_data.result_kind !== w.result_kind)
                    report_mismatch("result_kind", out_data.result_kind, w.result_kind);
                if (out_data.mixed_sample !== w.mixed_sample)
                    report_mismatch("mixed_sample", out_data.mixed_sample, w.mixed_sample);
                if (out_data.slot !== w.slot)
                    report_mismatch("slot", out_data.slot, w.slot);
                if (out_data.slot_ok !== w.slot_ok)
                    report_mismatch("slot_ok", out_data.slot_ok, w.slot_ok);
            end
        end
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_item_t it;
        int r;
        for (int i = 0; i < NUM_ONE; i++)
        begin
            os_base[i] = 0; os_len[i] = 0; os_pos[i] = 0; os_gain[i] = 0;
        end
        for (int i = 0; i < NUM_LOOP; i++)
        begin
            lp_base[i] = 0; lp_len[i] = 0; lp_phase[i] = 0; lp_gain[i] = 0; lp_rate[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fill a low RAM window including extremes
        for (int a = 0; a < 384; a++)
        begin
            it = make_item(ACT_WRITE);
            it.address = 16'(a);
            it.sample_value = (a % 3 == 0) ? 16'sh7fff : (a % 3 == 1) ? 16'sh8000
                              : 16'($urandom);
            pending_items.push_back(it);
        end
        it = make_item(ACT_WRITE);
        it.address = 16'hffff;
        pending_items.push_back(it);
        written_top = 384;
        pending_items.push_back(make_item(ACT_TICK));
        queue_start(ACT_START_ONE, 3, 16'hffff);
        queue_start(ACT_START_ONE, 0, 16'h0100);
        queue_start(ACT_START_ONE, 1, 16'h0000);
        queue_start(ACT_START_LP, 2, 16'hffff);
        queue_start(ACT_START_LP, 0, 16'h0080);
        queue_start(ACT_START_LP, 300, 16'h0100);
        it = make_item(ACT_SET_STEP); it.loop_index = 0; it.step = 16'hffff;
        pending_items.push_back(it);
        it = make_item(ACT_SET_STEP); it.loop_index = 1; it.step = 16'h0000;
        pending_items.push_back(it);
        it = make_item(ACT_SET_VOL); it.loop_index = 7; it.volume = 16'h0000;
        pending_items.push_back(it);
        pending_items.push_back(make_item(ACT_NONE6));
        pending_items.push_back(make_item(ACT_NONE7));
        repeat (4) pending_items.push_back(make_item(ACT_TICK));
        // exhaust the loop slots for a failed start
        repeat (9) queue_start(ACT_START_LP, 5, 16'h0200);
        pending_items.push_back(make_item(ACT_TICK));
        // hold off until everything is answered
        drain();

        // random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 29) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 76 : 29) : 0;
            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(99);
                if (r < 35)
                    pending_items.push_back(make_item(ACT_TICK));
                else if (r < 50)
                    pending_items.push_back(make_item(ACT_WRITE));
                else if (r < 68)
                    queue_start(ACT_START_ONE,
                        ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12),
                        16'($urandom));
                else if (r < 76)
                    queue_start(ACT_START_LP,
                        ($urandom_range(19) == 0) ? 384 : $urandom_range(0, 30),
                        16'($urandom));
                else if (r < 86)
                    pending_items.push_back(make_item(ACT_SET_STEP));
                else if (r < 96)
                    pending_items.push_back(make_item(ACT_SET_VOL));
                else
                    pending_items.push_back(make_item(action_t'($urandom_range(6, 7))));
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/svm_pkg.sv
rtl/svm_ram.sv
rtl/svm_scale.sv
rtl/sample_voice_mixer_top.sv
bench/sample_voice_mixer_top_tb.sv
